### hdl/eps_pkg.sv
`timescale 1ns / 1ps
// eps_pkg: shared constants and types for the prime sieve core.
// No dependencies; every other file but eps_chk imports it.
package eps_pkg;

  // Payload widths
  localparam int NUM_W = 16;

  // Defaults for the top-level parameter and the limit register
  localparam int unsigned MAX_NUMBER_DEF = 65535;
  localparam logic [NUM_W-1:0] LIMIT_RST = 16'hFFFF;

  // Query answer handed from the sequencer to the output stage
  typedef struct packed {
    logic is_prime;
    logic out_of_range;
  } eps_result_t;

endpackage

### hdl/eps_ifs.sv
`timescale 1ns / 1ps
// eps_ifs: valid/ready channel interfaces for query, result and limit write.
// Depends on eps_pkg.

interface eps_in_if
  import eps_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;
  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface eps_out_if
  import eps_pkg::*;
  ();
  logic valid;
  logic ready;
  logic is_prime;
  logic out_of_range;
  modport source (output valid, output is_prime, output out_of_range, input ready);
  modport sink   (input valid, input is_prime, input out_of_range, output ready);
endinterface

interface eps_cfg_if
  import eps_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] sieve_limit;
  modport source (output valid, output sieve_limit, input ready);
  modport sink   (input valid, input sieve_limit, output ready);
endinterface

### hdl/eps_alu.sv
`timescale 1ns / 1ps
// eps_alu: shared adder with limit compare used by the sieve and query steps.
// Depends on eps_pkg.
module eps_alu
  import eps_pkg::*;
#(
  parameter int W = 17
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] lim,
  output logic [W-1:0] sum,
  output logic         le
);

  // one add, one compare against the effective limit
  assign sum = a + b;
  assign le  = (sum <= lim);

endmodule

### hdl/eps_map.sv
`timescale 1ns / 1ps
// eps_map: one-bit primality map, one write port and one registered read port.
// Depends on eps_pkg.
module eps_map
  import eps_pkg::*;
#(
  parameter int AW    = 16,
  parameter int DEPTH = 65536
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/eps_seq.sv
`timescale 1ns / 1ps
// eps_seq: sequencer that builds the map with the shared ALU and answers queries.
// Depends on eps_pkg, eps_alu, eps_map.
module eps_seq
  import eps_pkg::*;
#(
  parameter int unsigned MAX_NUMBER = MAX_NUMBER_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] start_number,
  input  logic [NUM_W-1:0] sieve_limit,
  input  logic             cfg_wr,
  output logic             idle,
  output logic             res_valid,
  output eps_result_t      res
);

  localparam int AW    = $clog2(MAX_NUMBER + 1);
  localparam int DEPTH = MAX_NUMBER + 1;
  localparam int LW    = (AW > NUM_W) ? AW : NUM_W;
  localparam int W     = LW + 1;
  localparam int PW    = (LW + 1) / 2 + 2;
  localparam logic [LW-1:0] MAX_LW = LW'(MAX_NUMBER);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_PCHK  = 3'd2;
  localparam logic [2:0] S_PTEST = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_PNEXT = 3'd5;
  localparam logic [2:0] S_LOOK  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic             map_rdy_r, map_rdy_nxt;
  logic [W-1:0]     idx_r, idx_nxt;     // fill index, then current multiple
  logic [W-1:0]     sq_r, sq_nxt;       // p*p
  logic [PW-1:0]    p_r, p_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;

  logic [LW-1:0]    lim_ext;
  logic [W-1:0]     lim_eff;
  logic [W-1:0]     alu_a, alu_b, alu_sum;
  logic             alu_le;
  logic             map_we, map_wdata, rd_bit;
  logic [AW-1:0]    waddr, raddr;
  logic             fill_bit;

  // effective limit: register clipped to the map size
  assign lim_ext = LW'(sieve_limit);
  assign lim_eff = W'((lim_ext > MAX_LW) ? MAX_LW : lim_ext);

  // initial map value: 2 and odd numbers from 3 are candidates
  assign fill_bit = (idx_r == W'(2)) || (idx_r[0] && (idx_r != W'(1)));

  eps_alu #(.W(W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .lim (lim_eff),
    .sum (alu_sum),
    .le  (alu_le)
  );

  eps_map #(.AW(AW), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (waddr),
    .wdata (map_wdata),
    .raddr (raddr),
    .rdata (rd_bit)
  );

  assign idle = (state_r == S_IDLE);

  // sequencer next state
  always_comb begin
    state_nxt   = state_r;
    map_rdy_nxt = map_rdy_r;
    idx_nxt     = idx_r;
    sq_nxt      = sq_r;
    p_nxt       = p_r;
    num_nxt     = num_r;
    map_we      = 1'b0;
    map_wdata   = 1'b0;
    waddr       = AW'(idx_r);
    raddr       = AW'(p_r);
    alu_a       = sq_r;
    alu_b       = '0;
    res_valid   = 1'b0;
    res         = '0;
    unique case (state_r)
      S_IDLE: begin
        raddr = AW'(start_number);
        if (start) begin
          num_nxt = start_number;
          if (map_rdy_r) begin
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        map_we    = 1'b1;
        map_wdata = fill_bit;
        alu_a     = idx_r;
        alu_b     = W'(1);
        idx_nxt   = alu_sum;
        if (!alu_le) begin
          p_nxt     = PW'(3);
          sq_nxt    = W'(9);
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        // p*p within limit: fetch map[p]; else the map is done
        alu_a = sq_r;
        if (alu_le) begin
          state_nxt = S_PTEST;
        end else begin
          map_rdy_nxt = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_PTEST: begin
        if (rd_bit) begin
          idx_nxt   = sq_r;
          state_nxt = S_MARK;
        end else begin
          state_nxt = S_PNEXT;
        end
      end
      S_MARK: begin
        // clear odd multiple, step by 2p
        map_we    = 1'b1;
        map_wdata = 1'b0;
        alu_a     = idx_r;
        alu_b     = W'({p_r, 1'b0});
        idx_nxt   = alu_sum;
        if (!alu_le) begin
          state_nxt = S_PNEXT;
        end
      end
      S_PNEXT: begin
        // (p+2)^2 = p^2 + 4(p+1)
        alu_a     = sq_r;
        alu_b     = W'({p_r + PW'(1), 2'b00});
        sq_nxt    = alu_sum;
        p_nxt     = p_r + PW'(2);
        state_nxt = S_PCHK;
      end
      S_LOOK: begin
        raddr     = AW'(num_r);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        alu_a            = W'(num_r);
        res_valid        = 1'b1;
        res.out_of_range = !alu_le;
        res.is_prime     = alu_le && rd_bit;
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_wr) begin
      map_rdy_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      map_rdy_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      map_rdy_r <= map_rdy_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sq_r  <= sq_nxt;
    p_r   <= p_nxt;
    num_r <= num_nxt;
  end

endmodule

### hdl/eratosthenes_prime_sieve_core.sv
`timescale 1ns / 1ps
// Channel  | dir | payload            | beat when
// in_ch    | in  | number[15:0]       | valid && ready
// out_ch   | out | is_prime, out_of_range | valid && ready
// cfg_ch   | in  | sieve_limit[15:0]  | valid && ready (ready tied high)
//
// A query on a built map goes through S_RESP, which takes the registered map
// read, into the output register. The input reopens in the cycle after the result
// beat, so the core takes a new query only after the last result has been taken.
// The first query after reset or a limit write builds the map: a fill pass
// over 0..L, then per odd p with p*p <= L (L = effective limit) a test of
// map[p] and a clear of its odd multiples, all through the one shared adder.
// Reset (rst_n, synchronous) clears control state only; the map needs no
// clearing pass. A stalled result holds in the output register.
// Depends on eps_pkg, eps_ifs, eps_seq.
module eratosthenes_prime_sieve_core
  import eps_pkg::*;
#(
  parameter int unsigned MAX_NUMBER = MAX_NUMBER_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  eps_in_if.sink     in_ch,
  eps_out_if.source  out_ch,
  eps_cfg_if.sink    cfg_ch
);

  logic [NUM_W-1:0] limit_r;
  logic             out_valid_r;
  eps_result_t      out_res_r;
  logic             seq_idle, res_valid;
  eps_result_t      res;
  logic             in_beat, cfg_beat;

  assign cfg_ch.ready = 1'b1;
  assign cfg_beat     = cfg_ch.valid;
  assign in_ch.ready  = seq_idle && !out_valid_r;
  assign in_beat      = in_ch.valid && in_ch.ready;

  eps_seq #(.MAX_NUMBER(MAX_NUMBER)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_beat),
    .start_number (in_ch.number),
    .sieve_limit  (limit_r),
    .cfg_wr       (cfg_beat),
    .idle         (seq_idle),
    .res_valid    (res_valid),
    .res          (res)
  );

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_beat) begin
      limit_r <= cfg_ch.sieve_limit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_prime     = out_res_r.is_prime;
  assign out_ch.out_of_range = out_res_r.out_of_range;

endmodule

### hdl/eps_chk.sv
`timescale 1ns / 1ps
// eps_chk: port-level assertions for the prime sieve core, bound to the top.
// Depends on eratosthenes_prime_sieve_core.
module eps_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_prime,
  input logic out_of_range
);

  // one query at a time: after a beat the input is closed
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // no new query while a result waits
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // an out of range number is never prime
  a_range_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> !out_is_prime)
    else $error("out of range result flagged prime");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_prime) && $stable(out_of_range))
    else $error("stalled result dropped or changed");

endmodule

bind eratosthenes_prime_sieve_core eps_chk u_eps_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_is_prime (out_ch.is_prime),
  .out_of_range (out_ch.out_of_range)
);

### dv/eratosthenes_prime_sieve_core_test.sv
`timescale 1ns / 1ps
// Testbench for eratosthenes_prime_sieve_core: primality queries checked
// against an in-bench sieve over several limit settings, with random flow control.
// Depends on eps_pkg, eps_ifs and the core RTL.
module eratosthenes_prime_sieve_core_test;
  import eps_pkg::*;

  // Map size of the core under test
  localparam int unsigned MAP_TOP = MAX_NUMBER_DEF;
  localparam int unsigned IDLE_LIMIT = 600000;

  logic clk;
  logic rst_n;

  eps_in_if  in_ch ();
  eps_out_if out_ch ();
  eps_cfg_if cfg_ch ();

  eratosthenes_prime_sieve_core #(
    .MAX_NUMBER(MAP_TOP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow of the core state
  bit               sieve_map [0:65535];
  bit               sieve_built;
  logic [NUM_W-1:0] limit_shadow;

  logic [NUM_W-1:0] pending_numbers [$];
  eps_result_t      awaited_answers [$];
  int               error_count;

  function automatic int unsigned clamped_limit();
    return (limit_shadow > MAP_TOP) ? MAP_TOP : int'(limit_shadow);
  endfunction

  // Sieve of Eratosthenes over 0..lim
  function automatic void build_sieve(int unsigned lim);
    int unsigned i;
    int unsigned p;
    int unsigned m;
    for (i = 0; i <= lim; i++) sieve_map[i] = 1'b1;
    sieve_map[0] = 1'b0;
    if (lim >= 1) sieve_map[1] = 1'b0;
    for (i = 4; i <= lim; i += 2) sieve_map[i] = 1'b0;
    for (p = 3; p * p <= lim; p += 2) begin
      if (sieve_map[p]) begin
        for (m = p * p; m <= lim; m += 2 * p) sieve_map[m] = 1'b0;
      end
    end
    sieve_built = 1'b1;
  endfunction

  // Expected answer to one query; builds the map on first use
  function automatic eps_result_t sieve_answer(logic [NUM_W-1:0] num);
    eps_result_t ans;
    int unsigned lim;
    lim = clamped_limit();
    if (!sieve_built) build_sieve(lim);
    if (num > lim) begin
      ans.is_prime     = 1'b0;
      ans.out_of_range = 1'b1;
    end else begin
      ans.is_prime     = sieve_map[num];
      ans.out_of_range = 1'b0;
    end
    return ans;
  endfunction

  // Query mix: mostly in range, some near the limit, small, above it, or anywhere
  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned lim;
    int          v;
    lim = clamped_limit();
    case ($urandom_range(0, 9))
      6: begin
        v = int'(lim) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      7: v = $urandom_range(0, 65535);
      8: v = $urandom_range(0, 64);
      9: v = (lim < 65535) ? $urandom_range(lim + 1, 65535) : $urandom_range(0, 65535);
      default: v = $urandom_range(0, lim);
    endcase
    return v[NUM_W-1:0];
  endfunction

  // Query driver: bursts of random length separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  logic        launch;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        awaited_answers = {awaited_answers, sieve_answer(in_ch.number)};
      if (!in_ch.valid || in_ch.ready) begin
        launch = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_numbers.size() > 0) begin
          in_ch.number <= pending_numbers.pop_front();
          launch = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        in_ch.valid <= launch;
      end
    end
  end

  // Result monitor; ready follows a stall mode that changes every so often
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned stall_tick;
  logic        take;
  eps_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
      stall_tick   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_answers.size() == 0) begin
          $error("result beat with no query outstanding");
          error_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (out_ch.is_prime !== want.is_prime) begin
            $error("is_prime: expected %0b, got %0b", want.is_prime, out_ch.is_prime);
            error_count++;
          end
          if (out_ch.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b",
                   want.out_of_range, out_ch.out_of_range);
            error_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        0:       take = 1'b1;
        1:       take = ($urandom_range(0, 1) == 1);
        2:       take = ($urandom_range(0, 3) == 0);
        default: take = (stall_tick % 5 != 0);
      endcase
      out_ch.ready <= take;
    end
  end

  // Watchdog: too long without any beat on any channel
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("eratosthenes_prime_sieve_core_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every query has been sent and answered
  task automatic wait_drained();
    while (pending_numbers.size() != 0 || in_ch.valid || awaited_answers.size() != 0)
      @(posedge clk);
  endtask

  // Limit write, only issued with the core idle
  task automatic write_limit(logic [NUM_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.sieve_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    limit_shadow = value;
    sieve_built  = 1'b0;
    cfg_ch.valid <= 1'b0;
  endtask

  // Append one query to the pending list
  task automatic add_query(logic [NUM_W-1:0] num);
    pending_numbers = {pending_numbers, num};
  endtask

  task automatic queue_random(int count);
    repeat (count) add_query(pick_number());
  endtask

  // Edge queries around the current limit
  task automatic queue_limit_edges();
    int unsigned lim;
    lim = clamped_limit();
    add_query(16'd0);
    add_query(16'd1);
    add_query(16'd2);
    add_query(16'd3);
    add_query(lim[NUM_W-1:0]);
    if (lim > 0) add_query(lim[NUM_W-1:0] - 16'd1);
    if (lim < 65535) add_query(lim[NUM_W-1:0] + 16'd1);
    add_query(16'hFFFF);
  endtask

  // Sequence
  logic [NUM_W-1:0] phase_limit;

  initial begin
    error_count        = 0;
    quiet_cycles       = 0;
    limit_shadow       = LIMIT_RST;
    sieve_built        = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.number       = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.sieve_limit = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit: small primes, squares, edges
    pending_numbers = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd15,
                        16'd25, 16'd49, 16'd121, 16'd169, 16'd7919, 16'd32768,
                        16'd59999, 16'd60000, 16'd60001, 16'd65534, 16'd65535};
    queue_random(110);
    wait_drained();

    // Smallest legal limit, then the degenerate ones
    write_limit(16'd2);
    queue_limit_edges();
    queue_random(20);
    wait_drained();

    write_limit(16'd0);
    queue_limit_edges();
    queue_random(8);
    wait_drained();

    write_limit(16'd1);
    queue_limit_edges();
    queue_random(8);
    wait_drained();

    // Mostly small random limits
    repeat (6) begin
      phase_limit = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(257, 4096))
                                                : NUM_W'($urandom_range(3, 256));
      write_limit(phase_limit);
      queue_limit_edges();
      queue_random(37);
      wait_drained();
    end

    // Rewrite of the same value forces a rebuild
    write_limit(phase_limit);
    queue_random(20);
    wait_drained();

    // One mid-size limit below the map size
    write_limit(NUM_W'($urandom_range(16384, MAP_TOP - 1)));
    queue_limit_edges();
    queue_random(30);
    wait_drained();

    // Full register value
    write_limit(16'hFFFF);
    queue_limit_edges();
    queue_random(30);
    wait_drained();

    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("eratosthenes_prime_sieve_core_test OK");
    end else begin
      $display("eratosthenes_prime_sieve_core_test NOT OK");
    end
    $finish;
  end

endmodule
